### rtl/core/sbba_pkg.sv
// ----------------------------------------------------------------------------
// Slab allocator package
// Shared payload types, codes and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
package sbba_pkg;

   localparam int ADDR_W  = 48;
   localparam int BYTES_W = 21;
   localparam int COUNT_W = 11;
   localparam int CSR_W   = 48;
   localparam int WORD_W  = 64;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_INIT  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_RANGE   = 2'd2,
      ST_DOUBLE  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_BASE  = 2'd0,
      CSR_BYTES = 2'd1,
      CSR_COUNT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [ADDR_W-1:0] free_address;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [ADDR_W-1:0]  block_address;
      logic [COUNT_W-1:0] free_blocks;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture request, clear word pointer
      logic init_step;  // write init pattern to current word, advance
      logic scan_step;  // examine current word, advance
      logic div_start;  // begin offset division
      logic div_step;   // one quotient bit
      logic mul_step;   // one multiplier bit
      logic free_fetch; // read the word holding the freed block
      logic free_write; // set the bit, bump the count
      logic alloc_take; // clear the found bit
      logic respond;    // present the result
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_hit;
      logic scan_last;
      logic init_last;
      logic div_done;
      logic mul_done;
      logic below_base;
      logic idx_range;
      logic bit_set;
      logic total_zero;
   } sts_type;

endpackage

### rtl/core/sbba_datapath.sv
// ----------------------------------------------------------------------------
// Slab allocator datapath
// Bitmap memory, free count, restoring divider and shift-add multiplier.
// ----------------------------------------------------------------------------
module sbba_datapath
   import sbba_pkg::*;
#(
   parameter int MAX_BLOCKS = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  req_type             req,
   input  logic [ADDR_W-1:0]   base_ff,
   input  logic [BYTES_W-1:0]  bytes_ff,
   input  logic [COUNT_W-1:0]  count_ff,
   input  status_type          status_in,
   output rsp_type             rsp_data
);

   localparam int WORDS  = MAX_BLOCKS / WORD_W;
   localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int IDX_W  = $clog2(MAX_BLOCKS) + 1;
   localparam int TOT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int DCNT_W = $clog2(ADDR_W + 1);

   logic [WORD_W-1:0] map_mem [WORDS];
   logic [WIDX_W:0]   wp_ff, wp_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [WORD_W-1:0] rd_ff;
   logic [5:0]        bit_ff, bit_in;
   logic [ADDR_W-1:0] quo_ff, quo_in;
   logic [BYTES_W:0]  rem_ff, rem_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [ADDR_W-1:0] prod_ff, prod_in;
   logic [IDX_W-1:0]  mcand_ff, mcand_in;
   logic [ADDR_W-1:0] msh_ff, msh_in;
   rsp_type           rsp_ff;
   logic [BYTES_W-1:0] size;
   logic [TOT_W-1:0]  lim;
   logic [ADDR_W-1:0] offset;
   logic [BYTES_W:0]  trial;
   logic [5:0]        lowest;
   logic              rd_nz;
   logic [WORD_W-1:0] init_word;
   logic [TOT_W+6:0]  lo;
   logic [IDX_W-1:0]  fidx;

   assign size = (bytes_ff == '0) ? BYTES_W'(1) : bytes_ff;
   assign lim  = (32'(count_ff) > 32'(MAX_BLOCKS)) ? TOT_W'(MAX_BLOCKS) : TOT_W'(count_ff);
   assign offset = req.free_address - base_ff;
   assign fidx = IDX_W'(quo_ff);

   always_comb begin
      lowest = '0;
      for (int i = WORD_W - 1; i >= 0; i--)
         if (rd_ff[i]) lowest = 6'(i);
   end
   assign rd_nz = (rd_ff != '0);

   // Init pattern for word wp.
   always_comb begin
      lo = (TOT_W+7)'(wp_ff[WIDX_W-1:0]) << 6;
      if ((TOT_W+7)'(lim) >= lo + (TOT_W+7)'(WORD_W))
         init_word = '1;
      else if ((TOT_W+7)'(lim) > lo)
         init_word = (64'd1 << 6'((TOT_W+7)'(lim) - lo)) - 64'd1;
      else
         init_word = '0;
   end

   assign trial = {rem_ff[BYTES_W-1:0], quo_ff[ADDR_W-1]} - {1'b0, size};

   always_comb begin
      wp_in = wp_ff; total_in = total_ff; bit_in = bit_ff;
      quo_in = quo_ff; rem_in = rem_ff; dcnt_in = dcnt_ff;
      prod_in = prod_ff; mcand_in = mcand_ff; msh_in = msh_ff;
      if (cmd.load) wp_in = '0;
      if (cmd.init_step) begin
         wp_in = wp_ff + 1'b1;
         if (wp_ff == (WIDX_W+1)'(WORDS - 1)) total_in = lim;
      end
      if (cmd.scan_step) begin
         if (rd_nz) bit_in = lowest;
         else wp_in = wp_ff + 1'b1;
      end
      if (cmd.alloc_take) begin
         total_in = total_ff - 1'b1;
         prod_in  = '0;
         mcand_in = IDX_W'({wp_ff[WIDX_W-1:0], bit_ff});
         msh_in   = ADDR_W'(size);
      end
      if (cmd.mul_step) begin
         if (mcand_ff[0]) prod_in = prod_ff + msh_ff;
         mcand_in = mcand_ff >> 1;
         msh_in   = msh_ff << 1;
      end
      if (cmd.div_start) begin
         quo_in = offset; rem_in = '0; dcnt_in = DCNT_W'(ADDR_W);
      end
      if (cmd.div_step) begin
         if (!trial[BYTES_W]) rem_in = trial;
         else rem_in = {rem_ff[BYTES_W-1:0], quo_ff[ADDR_W-1]};
         quo_in = {quo_ff[ADDR_W-2:0], ~trial[BYTES_W]};
         dcnt_in = dcnt_ff - 1'b1;
      end
      if (cmd.free_write) total_in = total_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         wp_ff    <= '0;
      end else begin
         total_ff <= total_in;
         wp_ff    <= wp_in;
      end
      bit_ff <= bit_in; quo_ff <= quo_in; rem_ff <= rem_in; dcnt_ff <= dcnt_in;
      prod_ff <= prod_in; mcand_ff <= mcand_in; msh_ff <= msh_in;
   end

   // Bitmap memory: one write, one registered read port. Reset clears every
   // word so that no block is free.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WORDS; i++)
            map_mem[i] <= '0;
      end else if (cmd.init_step)
         map_mem[wp_ff[WIDX_W-1:0]] <= init_word;
      else if (cmd.alloc_take)
         map_mem[wp_ff[WIDX_W-1:0]] <= rd_ff & ~(64'd1 << bit_ff);
      else if (cmd.free_write)
         map_mem[fidx[WIDX_W+5:6]] <= rd_ff | (64'd1 << fidx[5:0]);
      if (cmd.free_fetch)
         rd_ff <= map_mem[fidx[WIDX_W+5:6]];
      else
         rd_ff <= map_mem[wp_in[WIDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_ff.status        <= status_in;
         rsp_ff.block_address <= (status_in == ST_OK && req.op == OP_ALLOC) ?
                                 base_ff + prod_ff : '0;
         rsp_ff.free_blocks   <= COUNT_W'(total_ff);
      end
   end
   assign rsp_data = rsp_ff;

   assign sts.scan_hit   = rd_nz;
   assign sts.scan_last  = (wp_ff == (WIDX_W+1)'(WORDS - 1));
   assign sts.init_last  = (wp_ff == (WIDX_W+1)'(WORDS - 1));
   assign sts.div_done   = (dcnt_ff == '0);
   assign sts.mul_done   = (mcand_ff == '0);
   assign sts.below_base = (req.free_address < base_ff);
   assign sts.idx_range  = (quo_ff >= ADDR_W'(lim));
   assign sts.bit_set    = rd_ff[fidx[5:0]];
   assign sts.total_zero = (total_ff == '0);

endmodule

### rtl/core/sbba_ctrl.sv
// ----------------------------------------------------------------------------
// Slab allocator controller
// Sequences init sweep, bitmap scan, multiply and divide steps.
// ----------------------------------------------------------------------------
module sbba_ctrl
   import sbba_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] op,
   input  sts_type    sts,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_valid,
   output status_type status_out
);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_INIT  = 10'b0000000010,
      S_SCAN  = 10'b0000000100,
      S_MUL   = 10'b0000001000,
      S_DIVS  = 10'b0000010000,
      S_DIV   = 10'b0000100000,
      S_FCHK  = 10'b0001000000,
      S_FRD   = 10'b0010000000,
      S_FWR   = 10'b0100000000,
      S_RESP  = 10'b1000000000
   } state_type;

   state_type  state_ff, state_in;
   status_type st_ff, st_in;
   logic       out_ff;
   logic [1:0] op_ff;

   always_comb begin
      state_in = state_ff;
      st_in    = st_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               st_in    = ST_OK;
               case (op)
                  OP_INIT:  state_in = S_INIT;
                  OP_ALLOC: state_in = S_SCAN;
                  OP_FREE:  state_in = S_DIVS;
                  default:  state_in = S_RESP;
               endcase
            end
         end
         S_INIT: begin
            cmd.init_step = 1'b1;
            if (sts.init_last) state_in = S_RESP;
         end
         S_SCAN: begin
            if (sts.total_zero) begin
               st_in = ST_EMPTY; state_in = S_RESP;
            end else if (sts.scan_hit) begin
               cmd.scan_step = 1'b1; state_in = S_MUL;
            end else if (sts.scan_last) begin
               st_in = ST_EMPTY; state_in = S_RESP;
            end else
               cmd.scan_step = 1'b1;
         end
         S_MUL: begin
            // First cycle takes the bit and seeds the multiplier.
            if (op_ff == OP_ALLOC) begin
               cmd.alloc_take = 1'b1;
            end else if (sts.mul_done)
               state_in = S_RESP;
            else
               cmd.mul_step = 1'b1;
         end
         S_DIVS: begin
            cmd.div_start = 1'b1; state_in = S_DIV;
         end
         S_DIV: begin
            if (sts.div_done) state_in = S_FCHK;
            else cmd.div_step = 1'b1;
         end
         S_FCHK: begin
            if (sts.below_base || sts.idx_range) begin
               st_in = ST_RANGE; state_in = S_RESP;
            end else begin
               cmd.free_fetch = 1'b1; state_in = S_FRD;
            end
         end
         S_FRD: begin
            // The word is fetched again so that it is still held for the write.
            if (sts.bit_set) begin
               st_in = ST_DOUBLE; state_in = S_RESP;
            end else begin
               cmd.free_fetch = 1'b1; state_in = S_FWR;
            end
         end
         S_FWR: begin
            cmd.free_write = 1'b1; state_in = S_RESP;
         end
         S_RESP: begin
            cmd.respond = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // op_ff marks the first S_MUL cycle by holding OP_ALLOC until taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_ff   <= 1'b0;
         op_ff    <= OP_NONE;
      end else begin
         state_ff <= state_in;
         out_ff   <= cmd.respond;
         if (cmd.scan_step && sts.scan_hit) op_ff <= OP_ALLOC;
         else if (cmd.alloc_take)          op_ff <= OP_NONE;
      end
      st_ff <= st_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = out_ff;
   assign status_out = st_ff;

   a_resp_one: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> state_ff == S_IDLE) else $error("respond not followed by idle");
   a_valid_after: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == S_RESP) else $error("stray strobe");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !(cmd.load)) else $error("load while busy");

endmodule

### rtl/core/slab_bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// Slab bitmap block allocator
// First-fit block allocator over a bitmap of 64-bit words with a free count.
// ----------------------------------------------------------------------------
// An init writes every bitmap word; an alloc on an empty slab answers without
// a scan, else it scans for the first free bit and multiplies its index by the size;
// a free runs a bit-serial divide of the 48-bit offset, then checks and sets the bit.
// One item is in work at a time; busy is high until the result strobe, and the
// receiver cannot stall, so the strobe lasts one cycle and the next item may follow.
// Reset clears the free count, the bitmap and control state, so no block is free.
// ----------------------------------------------------------------------------
module slab_bitmap_block_allocator
   import sbba_pkg::*;
#(
   parameter int MAX_BLOCKS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_data,
   output logic              rsp_valid,
   output rsp_type           rsp_data,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [CSR_W-1:0]  csr_data
);

   logic [ADDR_W-1:0]  base_ff;
   logic [BYTES_W-1:0] bytes_ff;
   logic [COUNT_W-1:0] count_ff;
   req_type            req_ff;
   cmd_type            cmd;
   sts_type            sts;
   status_type         st;

   // Configuration registers take writes at once; no read-back.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         bytes_ff <= BYTES_W'(64);
         count_ff <= COUNT_W'(1024);
      end else if (csr_write) begin
         case (csr_index)
            CSR_BASE:  base_ff  <= csr_data;
            CSR_BYTES: bytes_ff <= csr_data[BYTES_W-1:0];
            CSR_COUNT: count_ff <= csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // The item is held for the whole operation.
   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
   end

   sbba_ctrl u_ctrl (
      .clock, .reset, .start, .op(req_data.op), .sts, .cmd, .busy,
      .rsp_valid, .status_out(st)
   );

   sbba_datapath #(.MAX_BLOCKS(MAX_BLOCKS)) u_dp (
      .clock, .reset, .cmd, .sts, .req(req_ff), .base_ff, .bytes_ff, .count_ff,
      .status_in(st), .rsp_data
   );

endmodule
